// ===== rtl/core/gcke_pkg.sv =====
// gcke_pkg: shared types and constants of the grouped curve key encoder
// used by gcke_tables and grouped_curve_key_encoder; no dependencies

package gcke_pkg;

    // fixed field widths
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned KEY_W     = 64;
    localparam int unsigned TABLE_AW  = 10;
    localparam int unsigned ENTRY_W   = 8;
    localparam int unsigned TYPE_W    = 2;
    localparam int unsigned ORDER_W   = 6;
    localparam int unsigned BCOUNT_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DW    = 6;
    localparam int unsigned CMD_W     = 2;

    // batch mode group count limit
    localparam logic [BCOUNT_W-1:0] BATCH_MAX_GROUPS = 4'd8;

    // reset values of the configuration registers
    localparam logic [ORDER_W-1:0]  CURVE_ORDER_RST = 6'd32;
    localparam logic [BCOUNT_W-1:0] BATCH_COUNT_RST = 4'd8;
    localparam logic [TYPE_W-1:0]   BATCH_TYPE_RST  = 2'd0;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_KEY_WR  = 2'd0,
        CMD_TYPE_WR = 2'd1,
        CMD_ENCODE  = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURVE_ORDER  = 2'd0,
        REG_BATCH_MODE   = 2'd1,
        REG_BATCH_GROUPS = 2'd2,
        REG_BATCH_TYPE   = 2'd3
    } cfg_reg_t;

    // encoder control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } st_t;

    // table write request
    typedef struct packed {
        logic                key_en;
        logic                type_en;
        logic [TABLE_AW-1:0] addr;
        logic [ENTRY_W-1:0]  value;
    } tbl_wr_t;

    // table read request
    typedef struct packed {
        logic                en;
        logic [TABLE_AW-1:0] addr;
    } tbl_rd_req_t;

    // table read data, registered, valid in the cycle after the request
    typedef struct packed {
        logic [ENTRY_W-1:0] key;
        logic [TYPE_W-1:0]  next_type;
    } tbl_rd_t;

endpackage

// ===== rtl/core/gcke_tables.sv =====
// gcke_tables: key table and next-type table, one write and one read port each
// depends on gcke_pkg for the request and read data structs

module gcke_tables
    import gcke_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tbl_wr_t     wr,
    input  tbl_rd_req_t rd,
    output tbl_rd_t     rd_data
);

    localparam int unsigned DEPTH = 2 ** TABLE_AW;

    logic [ENTRY_W-1:0] key_table  [DEPTH];
    logic [TYPE_W-1:0]  type_table [DEPTH];
    logic [ENTRY_W-1:0] key_rd_reg;
    logic [TYPE_W-1:0]  type_rd_reg;

    // key table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            key_table[wr.addr] <= wr.value;
        end
        if (rd.en)
        begin
            key_rd_reg <= key_table[rd.addr];
        end
    end

    // next-type table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.type_en)
        begin
            type_table[wr.addr] <= wr.value[TYPE_W-1:0];
        end
        if (rd.en)
        begin
            type_rd_reg <= type_table[rd.addr];
        end
    end

    assign rd_data.key       = key_rd_reg;
    assign rd_data.next_type = type_rd_reg;

    // loads and the curve walk never share a cycle
    a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.key_en || wr.type_en) |-> !rd.en)
        else $error("table write during curve walk read");

endmodule

// ===== rtl/core/grouped_curve_key_encoder.sv =====
// grouped_curve_key_encoder: table-driven space-filling-curve key encoder
// depends on gcke_pkg and gcke_tables
//
// Usage:
//   in channel (in_valid/in_ready) carries one command per transaction:
//   cmd 0 loads entry_value into the key table at entry_address, cmd 1 loads
//   the low two bits into the next-type table, cmd 2 encodes (coord_x, coord_y)
//   and cmd 3 is dropped. Only an encode produces an out transaction
//   (out_valid/out_ready) carrying curve_key. The tables must be loaded
//   before the entries an encode visits are read.
//   The cfg channel (cfg_valid/cfg_ready, always ready) writes curve_order,
//   batch_mode, batch_group_count and batch_start_type by cfg_index.
//   Flow: table loads are taken back to back while no encode runs. An encode
//   of N groups keeps in_ready low until its key goes to the output register,
//   so no new transaction is taken during the walk (N = 8 at the default
//   order and group width); the walk issues one dependent read of both tables
//   per group through their single read port, the next type coming from the
//   previous read.
//   The output register lets a new transaction be taken while a key waits;
//   a finished key that finds the output still full holds the walk until the
//   receiver takes the old one. Reset clears control and the configuration
//   registers; table contents are kept and are undefined until loaded.

module grouped_curve_key_encoder
    import gcke_pkg::*;
#(
    parameter int unsigned GROUP_BITS = 4,
    parameter int unsigned MAX_ORDER  = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [COORD_W-1:0]   coord_x,
    input  logic [COORD_W-1:0]   coord_y,
    input  logic [TABLE_AW-1:0]  entry_address,
    input  logic [ENTRY_W-1:0]   entry_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KEY_W-1:0]     curve_key,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    // group geometry
    localparam int unsigned NORM_GROUPS = (MAX_ORDER + GROUP_BITS - 1) / GROUP_BITS;
    localparam int unsigned NG          = (NORM_GROUPS > 8) ? NORM_GROUPS : 8;
    localparam int unsigned PAD_W       = NG * GROUP_BITS;
    localparam int unsigned GI_W        = $clog2(NG);
    localparam int unsigned KSHIFT      = 2 * GROUP_BITS;
    localparam int unsigned ADDR_WW     = TYPE_W + 2 * GROUP_BITS;
    localparam logic [ENTRY_W-1:0] KMASK =
        (KSHIFT >= ENTRY_W) ? {ENTRY_W{1'b1}} : ENTRY_W'((1 << KSHIFT) - 1);
    localparam logic [ORDER_W-1:0] ORDER_MAX = ORDER_W'(MAX_ORDER);
    localparam logic [ORDER_W-1:0] ROUND_UP  = ORDER_W'(GROUP_BITS - 1);
    // ceil(order / GROUP_BITS) by reciprocal, exact for numerators below 64
    localparam int unsigned RECIP_SH = 9;
    localparam logic [9:0]  RECIP    = 10'((2 ** RECIP_SH + GROUP_BITS - 1) / GROUP_BITS);

    st_t state_reg, state_next;

    logic [ORDER_W-1:0]  curve_order_reg;
    logic                batch_mode_reg;
    logic [BCOUNT_W-1:0] batch_group_count_reg;
    logic [TYPE_W-1:0]   batch_start_type_reg;

    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [GI_W-1:0]     gi_reg;
    logic                issue_left_reg;
    logic                first_reg;
    logic                pend_reg;
    logic [TYPE_W-1:0]   start_type_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                out_valid_reg;
    logic [KEY_W-1:0]    curve_key_reg;

    logic                in_fire, enc_fire, slot_free, finishing, load_out, rd_en;
    logic [ORDER_W-1:0]  ord_clamp, ord_round, span;
    logic [15:0]         groups_prod;
    logic [ORDER_W-1:0]  groups_norm, groups_sel;
    logic [BCOUNT_W-1:0] groups_batch;
    logic [TYPE_W-1:0]   start_type_sel;
    logic [PAD_W-1:0]    x_pad, y_pad;
    logic [GROUP_BITS-1:0] gx, gy;
    logic [TYPE_W-1:0]   cur_type;
    logic [ADDR_WW-1:0]  addr_wide;
    logic [KEY_W-1:0]    key_next;

    tbl_wr_t     tbl_wr;
    tbl_rd_req_t tbl_rd;
    tbl_rd_t     tbl_data;

    assign in_fire   = in_valid && in_ready;
    assign enc_fire  = in_fire && (cmd == CMD_ENCODE);
    assign slot_free = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg       <= CURVE_ORDER_RST;
            batch_mode_reg        <= 1'b0;
            batch_group_count_reg <= BATCH_COUNT_RST;
            batch_start_type_reg  <= BATCH_TYPE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CURVE_ORDER:  curve_order_reg       <= cfg_data;
                REG_BATCH_MODE:   batch_mode_reg        <= cfg_data[0];
                REG_BATCH_GROUPS: batch_group_count_reg <= cfg_data[BCOUNT_W-1:0];
                REG_BATCH_TYPE:   batch_start_type_reg  <= cfg_data[TYPE_W-1:0];
                default:          ;
            endcase
        end
    end

    // group count and start type for a new encode
    always_comb
    begin
        if (curve_order_reg == '0)
            ord_clamp = ORDER_W'(1);
        else if (curve_order_reg > ORDER_MAX)
            ord_clamp = ORDER_MAX;
        else
            ord_clamp = curve_order_reg;
        ord_round   = ord_clamp + ROUND_UP;
        groups_prod = 16'(ord_round) * 16'(RECIP);
        groups_norm = groups_prod[RECIP_SH +: ORDER_W];
        span        = ORDER_W'(groups_norm * GROUP_BITS);

        if (batch_group_count_reg == '0)
            groups_batch = BCOUNT_W'(1);
        else if (batch_group_count_reg > BATCH_MAX_GROUPS)
            groups_batch = BATCH_MAX_GROUPS;
        else
            groups_batch = batch_group_count_reg;

        if (batch_mode_reg)
        begin
            groups_sel     = ORDER_W'(groups_batch);
            start_type_sel = batch_start_type_reg;
        end
        else
        begin
            groups_sel     = groups_norm;
            // padding parity: span - order is odd when their low bits differ
            start_type_sel = {1'b0, span[0] ^ ord_clamp[0]};
        end
    end

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (enc_fire) state_next = ST_RUN;
            ST_RUN:
            begin
                if (finishing)
                    state_next = slot_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        finishing = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_RUN:
            begin
                rd_en     = issue_left_reg;
                finishing = pend_reg && !issue_left_reg;
                load_out  = finishing && slot_free;
            end
            ST_HOLD: load_out = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // table loads straight from the input transaction
    assign tbl_wr.key_en  = in_fire && (cmd == CMD_KEY_WR);
    assign tbl_wr.type_en = in_fire && (cmd == CMD_TYPE_WR);
    assign tbl_wr.addr    = entry_address;
    assign tbl_wr.value   = entry_value;

    // coordinates padded with zeros above bit 31
    always_comb
    begin
        x_pad = '0;
        y_pad = '0;
        for (int b = 0; b < PAD_W && b < COORD_W; b++)
        begin
            x_pad[b] = x_reg[b];
            y_pad[b] = y_reg[b];
        end
    end

    // walk address: current type, x group, y group
    assign gx          = x_pad[gi_reg * GROUP_BITS +: GROUP_BITS];
    assign gy          = y_pad[gi_reg * GROUP_BITS +: GROUP_BITS];
    assign cur_type    = first_reg ? start_type_reg : tbl_data.next_type;
    assign addr_wide   = {cur_type, gx, gy};
    assign tbl_rd.en   = rd_en;
    assign tbl_rd.addr = TABLE_AW'(addr_wide);

    // key append of the returning entry
    assign key_next = (key_reg << KSHIFT) | KEY_W'(tbl_data.key & KMASK);

    // walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_left_reg <= 1'b0;
            first_reg      <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            pend_reg <= tbl_rd.en;
            if (enc_fire)
            begin
                issue_left_reg <= 1'b1;
                first_reg      <= 1'b1;
            end
            else if (tbl_rd.en)
            begin
                first_reg <= 1'b0;
                if (gi_reg == '0)
                    issue_left_reg <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge clk)
    begin
        if (enc_fire)
        begin
            x_reg          <= coord_x;
            y_reg          <= coord_y;
            gi_reg         <= GI_W'(groups_sel - ORDER_W'(1));
            start_type_reg <= start_type_sel;
            key_reg        <= '0;
        end
        else
        begin
            if (tbl_rd.en && (gi_reg != '0))
                gi_reg <= gi_reg - GI_W'(1);
            if ((state_reg == ST_RUN) && pend_reg)
                key_reg <= key_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            curve_key_reg <= (state_reg == ST_HOLD) ? key_reg : key_next;
    end

    assign out_valid = out_valid_reg;
    assign curve_key = curve_key_reg;

    gcke_tables u_tables (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_data)
    );

    // every issued read is collected in the following cycle
    a_read_collected: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_rd.en |=> pend_reg)
        else $error("table read data not marked pending");

    // the last group stops further reads
    a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_rd.en && (gi_reg == '0)) |=> !issue_left_reg)
        else $error("walk kept issuing after the last group");

    // a held key only waits behind an unaccepted output
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("holding a key while the output is free");

    // reads only happen while walking
    a_read_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_rd.en |-> (state_reg == ST_RUN))
        else $error("table read outside the curve walk");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for grouped_curve_key_encoder, table loads plus checked encodes
// depends on gcke_pkg and the grouped_curve_key_encoder rtl

module tb_top;
    import gcke_pkg::*;

    localparam int unsigned GB         = 4;
    localparam int unsigned IDLE_PCT   = 12;
    localparam int unsigned PHASE_CMDS = 48;
    localparam int unsigned NUM_PHASES = 15;
    localparam int unsigned DRAIN_CYC  = 12;
    localparam int unsigned STALL_MAX  = 2000;

    // command code that the block drops
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // one input transaction
    typedef struct {
        logic [CMD_W-1:0]    op;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [TABLE_AW-1:0] addr;
        logic [ENTRY_W-1:0]  value;
    } curve_cmd_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd           = '0;
    logic [COORD_W-1:0]   coord_x       = '0;
    logic [COORD_W-1:0]   coord_y       = '0;
    logic [TABLE_AW-1:0]  entry_address = '0;
    logic [ENTRY_W-1:0]   entry_value   = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [KEY_W-1:0]     curve_key;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_DW-1:0]    cfg_data      = '0;

    // pending commands and expected keys
    curve_cmd_t       cmd_q[$];
    logic [KEY_W-1:0] key_exp_q[$];

    // predictor copy of tables and registers
    logic [ENTRY_W-1:0] key_mem  [0:1023];
    logic [TYPE_W-1:0]  type_mem [0:1023];
    logic [ORDER_W-1:0]  order_reg  = CURVE_ORDER_RST;
    logic                batch_reg  = 1'b0;
    logic [BCOUNT_W-1:0] groups_reg = BATCH_COUNT_RST;
    logic [TYPE_W-1:0]   btype_reg  = BATCH_TYPE_RST;

    // table contents as they will be once every queued load is taken
    logic [TYPE_W-1:0] plan_type    [0:1023];
    bit                plan_key_set [0:1023];
    bit                plan_type_set[0:1023];

    bit          no_stall = 1'b0;
    int unsigned n_err    = 0;
    int unsigned n_keys   = 0;
    int unsigned n_loads  = 0;
    int unsigned n_cfg    = 0;
    int unsigned n_cmds   = 0;
    int unsigned idle_cyc = 0;

    grouped_curve_key_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .curve_key     (curve_key),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // group count and first type from the current registers
    function automatic void curve_start(output int unsigned ngroups,
                                        output logic [TYPE_W-1:0] ty);
        int unsigned ord;
        if (batch_reg)
        begin
            ngroups = (groups_reg == 0) ? 1 : ((groups_reg > 8) ? 8 : groups_reg);
            ty      = btype_reg;
        end
        else
        begin
            ord     = (order_reg == 0) ? 1 : ((order_reg > 32) ? 32 : order_reg);
            ngroups = (ord + GB - 1) / GB;
            ty      = TYPE_W'((ngroups * GB - ord) & 1);
        end
    endfunction

    // walk the tables from the top group down, appending key entries
    function automatic logic [KEY_W-1:0] predict_key(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        int unsigned         ngroups;
        logic [TYPE_W-1:0]   ty;
        logic [TABLE_AW-1:0] a;
        logic [KEY_W-1:0]    k;
        curve_start(ngroups, ty);
        k = '0;
        for (int i = ngroups; i > 0; i--)
        begin
            a  = {ty, x[(i-1)*GB +: GB], y[(i-1)*GB +: GB]};
            k  = {k[KEY_W-2*GB-1:0], key_mem[a]};
            ty = type_mem[a];
        end
        return k;
    endfunction

    // queue one command and track which entries it will load
    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [TABLE_AW-1:0] addr,
                            input logic [ENTRY_W-1:0] value);
        curve_cmd_t c;
        c.op    = op;
        c.x     = x;
        c.y     = y;
        c.addr  = addr;
        c.value = value;
        cmd_q.push_back(c);
        if (op == CMD_KEY_WR)
            plan_key_set[addr] = 1'b1;
        if (op == CMD_TYPE_WR)
        begin
            plan_type_set[addr] = 1'b1;
            plan_type[addr]     = value[TYPE_W-1:0];
        end
        if (op != CMD_NOP)
            n_cmds++;
    endtask

    // group value, often from a narrow set so entries get reused
    function automatic logic [GB-1:0] pick_group();
        logic [GB-1:0] pool [4] = '{4'h0, 4'hF, 4'h5, 4'hA};
        if ($urandom_range(0, 1))
            return pool[$urandom_range(0, 3)];
        return GB'($urandom_range(0, 15));
    endfunction

    // encode that only visits loaded entries; missing ones are loaded first
    task automatic add_encode(input logic [COORD_W-1:0] xin, input logic [COORD_W-1:0] yin,
                              input bit keep);
        int unsigned         ngroups;
        logic [TYPE_W-1:0]   ty;
        logic [TABLE_AW-1:0] a;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        x = xin;
        y = yin;
        curve_start(ngroups, ty);
        for (int i = ngroups; i > 0; i--)
        begin
            if (!keep)
            begin
                x[(i-1)*GB +: GB] = pick_group();
                y[(i-1)*GB +: GB] = pick_group();
            end
            a = {ty, x[(i-1)*GB +: GB], y[(i-1)*GB +: GB]};
            if (!plan_key_set[a])
                push_cmd(CMD_KEY_WR, $urandom, $urandom, a, ENTRY_W'($urandom_range(0, 255)));
            if (!plan_type_set[a])
                push_cmd(CMD_TYPE_WR, $urandom, $urandom, a, ENTRY_W'($urandom_range(0, 255)));
            ty = plan_type[a];
        end
        push_cmd(CMD_ENCODE, x, y, TABLE_AW'($urandom_range(0, 1023)),
                 ENTRY_W'($urandom_range(0, 255)));
    endtask

    // one register write, returns at the accepting edge with valid still high
    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_config(input logic [CFG_DW-1:0] ord, input logic [CFG_DW-1:0] mode,
                              input logic [CFG_DW-1:0] grp, input logic [CFG_DW-1:0] ty);
        cfg_write(REG_CURVE_ORDER, ord);
        cfg_write(REG_BATCH_MODE, mode);
        cfg_write(REG_BATCH_GROUPS, grp);
        cfg_write(REG_BATCH_TYPE, ty);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every command is taken and every key has come back
    task automatic drain();
        do
            @(posedge clk);
        while (cmd_q.size() != 0 || in_valid || key_exp_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        curve_cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (cmd_q.size() != 0 && (no_stall || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                c = cmd_q.pop_front();
                in_valid      <= 1'b1;
                cmd           <= c.op;
                coord_x       <= c.x;
                coord_y       <= c.y;
                entry_address <= c.addr;
                entry_value   <= c.value;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor: check keys, update predictor on every transaction
    always @(posedge clk)
    begin
        logic [KEY_W-1:0] exp_key;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (key_exp_q.size() == 0)
                begin
                    $display("%0t: unexpected curve_key, expected none got %h", $time, curve_key);
                    n_err++;
                end
                else
                begin
                    exp_key = key_exp_q.pop_front();
                    if (curve_key !== exp_key)
                    begin
                        $display("%0t: curve_key mismatch, expected %h got %h",
                                 $time, exp_key, curve_key);
                        n_err++;
                    end
                    n_keys++;
                end
            end
            if (in_valid && in_ready)
            begin
                case (cmd)
                    CMD_KEY_WR:
                    begin
                        key_mem[entry_address] = entry_value;
                        n_loads++;
                    end
                    CMD_TYPE_WR:
                    begin
                        type_mem[entry_address] = entry_value[TYPE_W-1:0];
                        n_loads++;
                    end
                    CMD_ENCODE:
                        key_exp_q.push_back(predict_key(coord_x, coord_y));
                    default: ;
                endcase
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CURVE_ORDER:  order_reg  = cfg_data[ORDER_W-1:0];
                    REG_BATCH_MODE:   batch_reg  = cfg_data[0];
                    REG_BATCH_GROUPS: groups_reg = cfg_data[BCOUNT_W-1:0];
                    REG_BATCH_TYPE:   btype_reg  = cfg_data[TYPE_W-1:0];
                    default: ;
                endcase
                n_cfg++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= STALL_MAX)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_MAX);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int unsigned target;
        int unsigned r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme entries and coordinates at the reset settings
        push_cmd(CMD_KEY_WR, '0, '0, 10'h000, 8'hFF);
        push_cmd(CMD_TYPE_WR, '1, '1, 10'h000, 8'hFC);
        push_cmd(CMD_KEY_WR, '0, '1, 10'h0FF, 8'hA5);
        push_cmd(CMD_TYPE_WR, '1, '0, 10'h0FF, 8'h03);
        push_cmd(CMD_KEY_WR, '1, '1, 10'h3FF, 8'h00);
        push_cmd(CMD_TYPE_WR, '0, '0, 10'h3FF, 8'hFF);
        push_cmd(CMD_NOP, '1, '1, 10'h3FF, 8'hFF);
        add_encode('0, '0, 1'b1);
        add_encode('1, '1, 1'b1);
        add_encode($urandom, $urandom, 1'b0);
        drain();

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            no_stall = (p == 3 || p == 4);
            case (p)
                1:  set_config(6'd1, 6'd0, 6'd8, 6'd0);
                2:  set_config(6'd0, 6'd0, 6'd8, 6'd0);
                3:  set_config(6'd63, 6'd0, 6'd8, 6'd0);
                4:  set_config(6'd13, 6'd0, 6'd8, 6'd0);
                5:  set_config(6'd6, 6'd0, 6'd8, 6'd0);
                6:  set_config(6'd32, 6'd1, 6'd0, 6'd3);
                7:  set_config(6'd32, 6'h3F, 6'd15, 6'd2);
                8:  set_config(6'd32, 6'd1, 6'd8, 6'd1);
                9:  set_config(6'd32, 6'd1, 6'd1, 6'h3C);
                10: set_config(6'd32, 6'h3E, 6'h3A, 6'd0);
                default:
                    set_config(CFG_DW'($urandom_range(0, 63)), CFG_DW'($urandom_range(0, 63)),
                               CFG_DW'($urandom_range(0, 63)), CFG_DW'($urandom_range(0, 63)));
            endcase

            // walks over loaded entries and loose loads about equally often, the rest dropped commands
            target = n_cmds + PHASE_CMDS;
            while (n_cmds < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    add_encode($urandom, $urandom, 1'b0);
                else if (r < 92)
                    push_cmd((r % 2) ? CMD_KEY_WR : CMD_TYPE_WR, $urandom, $urandom,
                             TABLE_AW'($urandom_range(0, 1023)),
                             ENTRY_W'($urandom_range(0, 255)));
                else
                    push_cmd(CMD_NOP, $urandom, $urandom, TABLE_AW'($urandom_range(0, 1023)),
                             ENTRY_W'($urandom_range(0, 255)));
            end
            drain();
        end

        n_err += key_exp_q.size();
        $display("run covered %0d checked keys, %0d table loads, %0d register writes",
                 n_keys, n_loads, n_cfg);
        $display("over %0d register settings, normal and batch mode with clamped values",
                 NUM_PHASES);
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
